// ===== rtl/nws_pkg.sv =====
// Shared types, codes and constants of the note waveform synthesizer.
// Used by nws_sine_lut and note_waveform_synth; depends on nothing else.
package nws_pkg;

    typedef enum logic [2:0] {
        WAVE_SILENT   = 3'd0,
        WAVE_SINE     = 3'd1,
        WAVE_WARM     = 3'd2,
        WAVE_TRIANGLE = 3'd3,
        WAVE_SQUARE   = 3'd4,
        WAVE_ORGAN    = 3'd5,
        WAVE_DOUBLE   = 3'd6,
        WAVE_MUTE     = 3'd7
    } wave_t;

    typedef enum logic [1:0] {
        FX_NONE     = 2'd0,
        FX_FUZZ     = 2'd1,
        FX_COMPRESS = 2'd2,
        FX_BYPASS   = 2'd3
    } effect_t;

    typedef struct packed {
        effect_t            eff;
        logic               clipped;
        logic               neg;
        logic signed [15:0] byp;
    } side_t;

    localparam int          DIV_QBITS   = 17;
    localparam int          DIV_W       = 52;
    localparam int          DEN_W       = 36;
    localparam int          RECIP_SHIFT = 30;
    localparam logic [29:0] DIV3_MULT   = 30'd357913942;
    localparam logic [14:0] FUZZ_U_MAX  = 15'd20480;
    localparam logic [16:0] TANH_T_MAX  = 17'd32768;
    localparam logic [20:0] PADE_N2     = 21'd1548288;
    localparam logic [26:0] PADE_N1     = 27'd70963200;
    localparam logic [32:0] PADE_N0     = 33'd553512960;
    localparam logic [23:0] PADE_D2     = 24'd12902400;
    localparam logic [29:0] PADE_D1     = 30'd255467520;
    localparam logic [35:0] PADE_D0     = 36'd553512960;

    function automatic logic [14:0] sin_poly(input int n, input int k);
        longint x;
        longint x2;
        longint t;
        longint y;
        x  = longint'(k) <<< (16 - (n - 2));
        x2 = (x * x) >>> 16;
        t  = (64'sd4640 * x2) >>> 16;
        t  = 64'sd42047 - t;
        t  = (t * x2) >>> 16;
        t  = 64'sd102944 - t;
        y  = (t * x) >>> 16;
        y  = (y + 64'sd2) >>> 2;
        if (y > 64'sd16384)
        begin
            y = 64'sd16384;
        end
        return 15'(y);
    endfunction

endpackage

// ===== rtl/nws_sine_lut.sv =====
// Quarter-wave sine lookup giving a signed Q14 value for one phase.
// Depends on nws_pkg for the table polynomial.
module nws_sine_lut #(
    parameter int TABLE_BITS = 8,
    parameter int PHASE_BITS = 32
) (
    input  logic [PHASE_BITS-1:0] phase,
    output logic signed [15:0]    value
);
    import nws_pkg::*;

    localparam int QBITS = TABLE_BITS - 2;
    localparam int QN    = 1 << QBITS;

    logic [14:0]           qtab [QN+1];
    logic [TABLE_BITS-1:0] idx;
    logic [QBITS-1:0]      r;
    logic [QBITS:0]        k;
    logic [14:0]           mag;

    genvar gi;
    generate
        for (gi = 0; gi <= QN; gi++)
        begin : g_tab
            assign qtab[gi] = sin_poly(TABLE_BITS, gi);
        end
    endgenerate

    assign idx   = phase[PHASE_BITS-1 -: TABLE_BITS];
    assign r     = idx[QBITS-1:0];
    assign k     = idx[QBITS] ? (QBITS+1)'(QN) - {1'b0, r} : {1'b0, r};
    assign mag   = qtab[k];
    assign value = idx[TABLE_BITS-1] ? 16'(-$signed({1'b0, mag})) : $signed({1'b0, mag});

endmodule

// ===== rtl/note_waveform_synth.sv =====
// Phase-accumulator oscillator: sine, warm, triangle, square, organ, doubled sine,
// then optional tanh fuzz or soft-knee compression. Depends on nws_pkg, nws_sine_lut.
// Accepts one sample per cycle unless held by output backpressure.
// The 28 stages include 17 for the fuzz divider; input stalls only on output backpressure.
// Reset clears both phase accumulators and all stage valid flags; data registers are not reset.
module note_waveform_synth #(
    parameter int AMPLITUDE       = 8192,
    parameter int HARMONIC_COUNT  = 10,
    parameter int SINE_TABLE_BITS = 8,
    parameter int PHASE_BITS      = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // note_step[23:0], octave[26:24], waveform[29:27], effect[31:30]
    input  logic        s_tuser,   // note_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample[15:0]
    output logic        m_tuser    // clipped
);
    import nws_pkg::*;

    localparam int P      = PHASE_BITS;
    localparam int NH     = (HARMONIC_COUNT > 6) ? HARMONIC_COUNT : 6;
    localparam int TW     = P + 3;
    localparam int TPW    = TW + 16;
    localparam int ST_DIV = 10;
    localparam int NS     = ST_DIV + DIV_QBITS + 1;
    localparam int ST_OUT = NS - 1;
    localparam logic [30:0] RECIP = 31'((64'd1 << RECIP_SHIFT) / AMPLITUDE);
    localparam logic [P-1:0] HALF = P'(64'd1 << (P - 1));

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[ST_OUT] = !vld_reg[ST_OUT] || m_tready;
        for (int i = ST_OUT - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[ST_OUT];

    // phase accumulators
    logic [23:0]  note_step;
    logic [2:0]   octave;
    logic [30:0]  step_wide;
    logic [27:0]  step_u;
    logic [P-1:0] step;
    logic [58:0]  div3_prod;
    logic [P-1:0] sub_inc;
    logic [P-1:0] ph_in;
    logic [P-1:0] sub_in;
    logic [P-1:0] phase_acc_reg;
    logic [P-1:0] sub_acc_reg;
    logic         accept;

    assign note_step = s_tdata[23:0];
    assign octave    = s_tdata[26:24];
    assign step_wide = {7'd0, note_step} << octave;
    assign step_u    = step_wide[30:3] >> (32 - P);
    assign step      = P'(step_u);
    assign div3_prod = {30'd0, step_u, 1'b0} * {29'd0, DIV3_MULT};
    assign sub_inc   = P'(div3_prod[58:30]);
    assign ph_in     = s_tuser ? '0 : phase_acc_reg;
    assign sub_in    = s_tuser ? '0 : sub_acc_reg;
    assign accept    = s_tvalid && en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            sub_acc_reg   <= '0;
        end
        else if (accept)
        begin
            phase_acc_reg <= ph_in + step;
            sub_acc_reg   <= sub_in + sub_inc;
        end
    end

    // stage A: input register
    logic [P-1:0] a_ph_reg;
    logic [P-1:0] a_sub_reg;
    wave_t        a_wave_reg;
    effect_t      a_eff_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_ph_reg   <= ph_in;
            a_sub_reg  <= sub_in;
            a_wave_reg <= wave_t'(s_tdata[29:27]);
            a_eff_reg  <= effect_t'(s_tdata[31:30]);
        end
    end

    // stage B: sine lookups
    logic signed [15:0] lut_s [NH];
    logic signed [15:0] lut_sub;
    logic signed [15:0] b_s_reg [NH];
    logic signed [15:0] b_sub_reg;
    logic [P-1:0]       b_ph_reg;
    wave_t              b_wave_reg;
    effect_t            b_eff_reg;

    genvar gh;
    generate
        for (gh = 0; gh < NH; gh++)
        begin : g_harm
            logic [P-1:0] hph;
            assign hph = a_ph_reg * P'(gh + 1);
            nws_sine_lut #(
                .TABLE_BITS (SINE_TABLE_BITS),
                .PHASE_BITS (P)
            ) u_lut (
                .phase (hph),
                .value (lut_s[gh])
            );
        end
    endgenerate

    nws_sine_lut #(
        .TABLE_BITS (SINE_TABLE_BITS),
        .PHASE_BITS (P)
    ) u_lut_sub (
        .phase (a_sub_reg),
        .value (lut_sub)
    );

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b_s_reg    <= lut_s;
            b_sub_reg  <= lut_sub;
            b_ph_reg   <= a_ph_reg;
            b_wave_reg <= a_wave_reg;
            b_eff_reg  <= a_eff_reg;
        end
    end

    // stage C: components
    function automatic logic signed [15:0] scomp(input logic signed [15:0] s);
        logic signed [31:0] p;
        logic signed [31:0] m;
        p = $signed(32'(AMPLITUDE)) * 32'(s);
        m = p[31] ? -p : p;
        return p[31] ? 16'(-(m >>> 14)) : 16'(m >>> 14);
    endfunction

    logic signed [35:0]   wprod [HARMONIC_COUNT];
    logic signed [35:0]   c_warm_next;
    logic signed [17:0]   c_organ_next;
    logic [P-1:0]         c_d;
    logic signed [TW-1:0] c_tri_next;
    logic signed [15:0]   c_c1_reg;
    logic signed [17:0]   c_organ_reg;
    logic signed [35:0]   c_warm_reg;
    logic signed [TW-1:0] c_tri_reg;
    logic                 c_sq_reg;
    wave_t                c_wave_reg;
    effect_t              c_eff_reg;

    genvar gw;
    generate
        for (gw = 0; gw < HARMONIC_COUNT; gw++)
        begin : g_weight
            localparam int W = (65536 + (gw + 1) / 2) / (gw + 1);
            assign wprod[gw] = 36'(b_s_reg[gw]) * $signed(36'(W));
        end
    endgenerate

    always_comb
    begin
        c_warm_next = '0;
        for (int g = 0; g < HARMONIC_COUNT; g++)
        begin
            c_warm_next = c_warm_next + wprod[g];
        end
        c_organ_next = 18'(scomp(b_s_reg[0])) + 18'(scomp(b_s_reg[1]))
                     + 18'(scomp(b_s_reg[2])) + 18'(scomp(b_s_reg[5]))
                     + 18'(scomp(b_sub_reg));
        c_d          = (b_ph_reg >= HALF) ? b_ph_reg - HALF : HALF - b_ph_reg;
        c_tri_next   = $signed(TW'(1) << P) - $signed(TW'({c_d, 2'b00}));
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c_c1_reg    <= scomp(b_s_reg[0]);
            c_organ_reg <= c_organ_next;
            c_warm_reg  <= c_warm_next;
            c_tri_reg   <= c_tri_next;
            c_sq_reg    <= b_ph_reg < HALF;
            c_wave_reg  <= b_wave_reg;
            c_eff_reg   <= b_eff_reg;
        end
    end

    // stage D: waveform select and saturation
    logic signed [51:0]    d_pw;
    logic signed [51:0]    d_pwm;
    logic signed [21:0]    d_warm;
    logic signed [TPW-1:0] d_pt;
    logic signed [TPW-1:0] d_ptm;
    logic signed [21:0]    d_tri;
    logic signed [21:0]    d_sum;
    logic signed [15:0]    d_x_next;
    logic                  d_clip_next;
    logic signed [15:0]    d_x_reg;
    logic                  d_clip_reg;
    effect_t               d_eff_reg;

    always_comb
    begin
        d_pw   = 52'(c_warm_reg) * $signed(52'(AMPLITUDE));
        d_pwm  = d_pw[51] ? -d_pw : d_pw;
        d_warm = d_pw[51] ? -22'(d_pwm >>> 30) : 22'(d_pwm >>> 30);
        d_pt   = TPW'(c_tri_reg) * $signed(TPW'(AMPLITUDE));
        d_ptm  = d_pt[TPW-1] ? -d_pt : d_pt;
        d_tri  = d_pt[TPW-1] ? -22'(d_ptm >>> P) : 22'(d_ptm >>> P);
        unique case (c_wave_reg)
            WAVE_SINE:     d_sum = 22'(c_c1_reg);
            WAVE_WARM:     d_sum = d_warm;
            WAVE_TRIANGLE: d_sum = d_tri;
            WAVE_SQUARE:   d_sum = c_sq_reg ? $signed(22'(AMPLITUDE)) : -$signed(22'(AMPLITUDE));
            WAVE_ORGAN:    d_sum = 22'(c_organ_reg);
            WAVE_DOUBLE:   d_sum = 22'(c_c1_reg) + 22'(c_c1_reg);
            default:       d_sum = '0;
        endcase
        priority if (d_sum > 22'sd32767)
        begin
            d_x_next    = 16'sh7fff;
            d_clip_next = 1'b1;
        end
        else if (d_sum < -22'sd32768)
        begin
            d_x_next    = 16'sh8000;
            d_clip_next = 1'b1;
        end
        else
        begin
            d_x_next    = 16'(d_sum);
            d_clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            d_x_reg    <= d_x_next;
            d_clip_reg <= d_clip_next;
            d_eff_reg  <= c_eff_reg;
        end
    end

    // stage E: magnitude, reciprocal product, compression
    logic signed [16:0] e_xs;
    logic signed [16:0] e_axs;
    logic [16:0]        e_ax;
    logic [29:0]        e_n;
    logic [59:0]        e_prod;
    logic [17:0]        e_ax2;
    logic [17:0]        e_cm;
    logic signed [15:0] e_comp;
    side_t              e_side_next;
    logic [29:0]        e_q_reg;
    logic [29:0]        e_n_reg;
    side_t              e_side_reg;

    always_comb
    begin
        e_xs   = 17'(d_x_reg);
        e_axs  = e_xs[16] ? -e_xs : e_xs;
        e_ax   = e_axs;
        e_n    = 30'({e_ax, 14'd0});
        e_prod = {30'd0, e_n} * {29'd0, RECIP};
        e_ax2  = {e_ax, 1'b0};
        e_cm   = (18'(3 * AMPLITUDE) + e_ax2) >> 3;
        if (e_ax2 > 18'(AMPLITUDE))
        begin
            e_comp = d_x_reg[15] ? -$signed(16'(e_cm)) : $signed(16'(e_cm));
        end
        else
        begin
            e_comp = d_x_reg;
        end
        e_side_next.eff     = d_eff_reg;
        e_side_next.clipped = d_clip_reg;
        e_side_next.neg     = d_x_reg[15];
        e_side_next.byp     = (d_eff_reg == FX_COMPRESS) ? e_comp : d_x_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            e_q_reg    <= e_prod[59:30];
            e_n_reg    <= e_n;
            e_side_reg <= e_side_next;
        end
    end

    // stage F: quotient correction and clamp of u
    logic [43:0] f_prod;
    logic [29:0] f_rem;
    logic [29:0] f_q;
    logic [14:0] f_u_reg;
    side_t       f_side_reg;

    always_comb
    begin
        f_prod = {14'd0, e_q_reg} * 44'(AMPLITUDE);
        f_rem  = e_n_reg - f_prod[29:0];
        f_q    = (f_rem >= 30'(AMPLITUDE)) ? e_q_reg + 30'd1 : e_q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            f_u_reg    <= (f_q > 30'(FUZZ_U_MAX)) ? FUZZ_U_MAX : f_q[14:0];
            f_side_reg <= e_side_reg;
        end
    end

    // stage G: v = u^2 in Q12
    logic [29:0] g_uu;
    logic [14:0] g_u_reg;
    logic [16:0] g_v_reg;
    side_t       g_side_reg;

    assign g_uu = {15'd0, f_u_reg} * {15'd0, f_u_reg};

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            g_u_reg    <= f_u_reg;
            g_v_reg    <= g_uu[28:12];
            g_side_reg <= f_side_reg;
        end
    end

    // stage H: first Horner steps
    logic [37:0] h_np;
    logic [23:0] h_dsum;
    logic [40:0] h_dp;
    logic [14:0] h_u_reg;
    logic [16:0] h_v_reg;
    logic [25:0] h_n1_reg;
    logic [28:0] h_d1_reg;
    side_t       h_side_reg;

    always_comb
    begin
        h_np   = 38'(21'(g_v_reg) + PADE_N2) * 38'(g_v_reg);
        h_dsum = 24'(g_v_reg) * 24'd28 + PADE_D2;
        h_dp   = 41'(h_dsum) * 41'(g_v_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            h_u_reg    <= g_u_reg;
            h_v_reg    <= g_v_reg;
            h_n1_reg   <= h_np[37:12];
            h_d1_reg   <= h_dp[40:12];
            h_side_reg <= g_side_reg;
        end
    end

    // stage I: numerator and denominator
    logic [43:0]      i_np;
    logic [46:0]      i_dp;
    logic [14:0]      i_u_reg;
    logic [32:0]      i_num_reg;
    logic [DEN_W-1:0] i_den_reg;
    side_t            i_side_reg;

    always_comb
    begin
        i_np = 44'(27'(h_n1_reg) + PADE_N1) * 44'(h_v_reg);
        i_dp = 47'(30'(h_d1_reg) + PADE_D1) * 47'(h_v_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            i_u_reg    <= h_u_reg;
            i_num_reg  <= 33'(i_np[43:12]) + PADE_N0;
            i_den_reg  <= 36'(i_dp[46:12]) + PADE_D0;
            i_side_reg <= h_side_reg;
        end
    end

    // stage J: dividend
    logic [47:0]      j_prod;
    logic [DIV_W-1:0] j_div_reg;
    logic [DEN_W-1:0] j_den_reg;
    side_t            j_side_reg;

    assign j_prod = 48'(i_u_reg) * 48'(i_num_reg);

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            j_div_reg  <= DIV_W'({j_prod, 3'b000});
            j_den_reg  <= i_den_reg;
            j_side_reg <= i_side_reg;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [DIV_W-1:0]     dv_rem_reg  [DIV_QBITS];
    logic [DEN_W-1:0]     dv_den_reg  [DIV_QBITS];
    logic [DIV_QBITS-1:0] dv_q_reg    [DIV_QBITS];
    side_t                dv_side_reg [DIV_QBITS];

    genvar gk;
    generate
        for (gk = 0; gk < DIV_QBITS; gk++)
        begin : g_div
            localparam int B = DIV_QBITS - 1 - gk;
            logic [DIV_W-1:0]     rin;
            logic [DEN_W-1:0]     din;
            logic [DIV_QBITS-1:0] qin;
            side_t                sdin;
            logic [DIV_W-1:0]     trial;
            logic                 take;
            if (gk == 0)
            begin : g_first
                assign rin  = j_div_reg;
                assign din  = j_den_reg;
                assign qin  = '0;
                assign sdin = j_side_reg;
            end
            else
            begin : g_next
                assign rin  = dv_rem_reg[gk-1];
                assign din  = dv_den_reg[gk-1];
                assign qin  = dv_q_reg[gk-1];
                assign sdin = dv_side_reg[gk-1];
            end
            assign trial = DIV_W'(din) << B;
            assign take  = rin >= trial;
            always_ff @(posedge clk)
            begin
                if (en[ST_DIV+gk])
                begin
                    dv_rem_reg[gk]  <= take ? rin - trial : rin;
                    dv_den_reg[gk]  <= din;
                    dv_q_reg[gk]    <= {qin[DIV_QBITS-2:0], take};
                    dv_side_reg[gk] <= sdin;
                end
            end
        end
    endgenerate

    // output register
    side_t              k_side;
    logic [16:0]        k_t;
    logic [30:0]        k_p;
    logic signed [15:0] k_fuzz;
    logic [15:0]        sample_next;

    always_comb
    begin
        k_side = dv_side_reg[DIV_QBITS-1];
        k_t    = (dv_q_reg[DIV_QBITS-1] > TANH_T_MAX) ? TANH_T_MAX : dv_q_reg[DIV_QBITS-1];
        k_p    = 31'(AMPLITUDE) * 31'(k_t);
        k_fuzz = k_side.neg ? -$signed(16'(k_p >> 15)) : $signed(16'(k_p >> 15));
        sample_next = (k_side.eff == FX_FUZZ) ? k_fuzz : k_side.byp;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            m_tdata <= sample_next;
            m_tuser <= k_side.clipped;
        end
    end

endmodule
